### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the descriptor slot table checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### src/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg
// Types, codes and defaults shared by the descriptor slot table modules.
// ----------------------------------------------------------------------------
package dst_pkg;

   localparam int SLOTS_DEFAULT       = 64;
   localparam int HANDLE_BITS_DEFAULT = 16;

   // request codes
   localparam logic [2:0] OP_LOOKUP     = 3'd0;
   localparam logic [2:0] OP_RESERVE    = 3'd1;
   localparam logic [2:0] OP_INSTALL    = 3'd2;
   localparam logic [2:0] OP_DUP_TO     = 3'd3;
   localparam logic [2:0] OP_CLOSE      = 3'd4;
   localparam logic [2:0] OP_GET_FLAGS  = 3'd5;
   localparam logic [2:0] OP_SET_FLAGS  = 3'd6;
   localparam logic [2:0] OP_DUP_LOWEST = 3'd7;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_BADF  = 2'd1;
   localparam logic [1:0] STATUS_INVAL = 2'd2;
   localparam logic [1:0] STATUS_NOSPC = 2'd3;

   // slot states
   localparam logic [1:0] SLOT_FREE     = 2'd0;
   localparam logic [1:0] SLOT_RESERVED = 2'd1;
   localparam logic [1:0] SLOT_OPEN     = 2'd2;

   typedef struct packed {
      logic       en;
      logic [1:0] state;
      logic [7:0] flags;
   } cell_wr_type;

   typedef struct packed {
      logic load;
      logic shift;
   } probe_ctl_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] state_a;
      logic [7:0] flags_a;
      logic [1:0] state_b;
   } row_status_type;

   typedef enum logic [4:0] {
      FSM_IDLE = 5'b00001,
      FSM_READ = 5'b00010,
      FSM_EVAL = 5'b00100,
      FSM_SCAN = 5'b01000,
      FSM_DONE = 5'b10000
   } fsm_type;

endpackage

### src/dst_cell.sv
// ----------------------------------------------------------------------------
// dst_cell
// One slot: state and flags, plus the search probe handed to the next cell.
// ----------------------------------------------------------------------------
module dst_cell #(
   parameter int IDX_W = 6,
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dst_pkg::cell_wr_type     wr,
   input  logic [IDX_W-1:0]         wr_idx,
   input  logic [IDX_W-1:0]         sel_a,
   input  logic [IDX_W-1:0]         sel_b,
   input  logic [IDX_W-1:0]         start_idx,
   input  dst_pkg::probe_ctl_type   pctl,
   input  logic                     probe_in,
   output logic                     probe_out,
   output dst_pkg::row_status_type  status
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic [7:0] flags_ff;
   logic [7:0] flags_in;
   logic       probe_ff;
   logic       probe_in_nxt;
   logic       is_free;

   assign is_free = (state_ff == dst_pkg::SLOT_FREE);

   always_comb begin
      state_in = state_ff;
      flags_in = flags_ff;
      if (wr.en && (wr_idx == MY_IDX)) begin
         state_in = wr.state;
         flags_in = wr.flags;
      end
   end

   always_comb begin
      probe_in_nxt = probe_ff;
      priority if (pctl.load) begin
         probe_in_nxt = (start_idx == MY_IDX);
      end else if (pctl.shift) begin
         probe_in_nxt = probe_in;
      end else begin
         probe_in_nxt = probe_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dst_pkg::SLOT_FREE;
         flags_ff <= '0;
         probe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         flags_ff <= flags_in;
         probe_ff <= probe_in_nxt;
      end
   end

   // pass the probe on past a busy slot, stop at a free one
   assign probe_out      = probe_ff & ~is_free;
   assign status.hit     = probe_ff & is_free;
   assign status.state_a = (sel_a == MY_IDX) ? state_ff : dst_pkg::SLOT_FREE;
   assign status.flags_a = (sel_a == MY_IDX) ? flags_ff : 8'd0;
   assign status.state_b = (sel_b == MY_IDX) ? state_ff : dst_pkg::SLOT_FREE;

endmodule

### src/dst_cell_row.sv
// ----------------------------------------------------------------------------
// dst_cell_row
// Chain of slot cells with the probe ripple and the combined status view.
// ----------------------------------------------------------------------------
module dst_cell_row #(
   parameter int SLOTS = dst_pkg::SLOTS_DEFAULT,
   parameter int IDX_W = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dst_pkg::cell_wr_type     wr,
   input  logic [IDX_W-1:0]         wr_idx,
   input  logic [IDX_W-1:0]         sel_a,
   input  logic [IDX_W-1:0]         sel_b,
   input  logic [IDX_W-1:0]         start_idx,
   input  dst_pkg::probe_ctl_type   pctl,
   output dst_pkg::row_status_type  status
);

   logic [SLOTS:0]          probe_link;
   dst_pkg::row_status_type cell_status [SLOTS];

   assign probe_link[0] = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      dst_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr        (wr),
         .wr_idx    (wr_idx),
         .sel_a     (sel_a),
         .sel_b     (sel_b),
         .start_idx (start_idx),
         .pctl      (pctl),
         .probe_in  (probe_link[i]),
         .probe_out (probe_link[i+1]),
         .status    (cell_status[i])
      );
   end

   always_comb begin
      status = '0;
      for (int i = 0; i < SLOTS; i++) begin
         status = status | cell_status[i];
      end
   end

endmodule

### src/descriptor_slot_table.sv
// ----------------------------------------------------------------------------
// descriptor_slot_table
// Fixed table of descriptor slots: lookup, reserve, install, dup, close, flags.
//
//   channel  | ports                                   | direction
//   req      | req_valid/req_ready, op fd target handle | in
//   rsp      | rsp_valid/rsp_ready, status fd handle    | out
//
// Every request passes the READ, EVAL and DONE states from transfer to result; reserve
// and dup_lowest that search pass a SCAN state between EVAL and DONE, in which the probe walks
// the cells from the start index towards the last slot. Reset clears every slot.
// req_ready is low from a request transfer until its result is loaded into
// the output register; a stalled rsp holds that register and a new request
// is taken meanwhile.
// ----------------------------------------------------------------------------
module descriptor_slot_table #(
   parameter int SLOTS       = dst_pkg::SLOTS_DEFAULT,
   parameter int HANDLE_BITS = dst_pkg::HANDLE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_op,
   input  logic signed [15:0] req_fd,
   input  logic signed [15:0] req_target_fd,
   input  logic [15:0]        req_handle,
   input  logic [7:0]         req_flags,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [14:0]        rsp_result_fd,
   output logic [15:0]        rsp_handle_out,
   output logic               rsp_handle_valid,
   output logic [7:0]         rsp_flags_out
);

   localparam int               IDX_W    = $clog2(SLOTS);
   localparam logic [15:0]      SLOTS_16 = 16'(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   dst_pkg::fsm_type fsm_ff, fsm_in;

   logic [2:0]  op_ff;
   logic [15:0] fd_ff;
   logic [15:0] tgt_ff;
   logic [15:0] handle_ff;
   logic [7:0]  flags_ff;

   logic [1:0]  src_state_ff;
   logic [7:0]  src_flags_ff;
   logic [1:0]  tgt_state_ff;

   logic [IDX_W-1:0] scan_ff, scan_in;

   logic [1:0]  res_status_ff, res_status_in;
   logic [14:0] res_fd_ff, res_fd_in;
   logic [15:0] res_hout_ff, res_hout_in;
   logic        res_hval_ff, res_hval_in;
   logic [7:0]  res_fout_ff, res_fout_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [14:0] rsp_fd_ff;
   logic [15:0] rsp_hout_ff;
   logic        rsp_hval_ff;
   logic [7:0]  rsp_fout_ff;

   logic [HANDLE_BITS-1:0] handle_mem [SLOTS];
   logic [HANDLE_BITS-1:0] rd_a_ff;
   logic [HANDLE_BITS-1:0] rd_b_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_widx;
   logic [HANDLE_BITS-1:0] mem_wdata;

   logic [IDX_W-1:0]        fd_idx;
   logic [IDX_W-1:0]        tgt_idx;
   logic                    fd_ok;
   logic                    tgt_ok;
   logic                    src_open;
   logic                    req_xfer;
   logic                    rsp_load;
   dst_pkg::cell_wr_type    wr;
   logic [IDX_W-1:0]        wr_idx;
   dst_pkg::probe_ctl_type  pctl;
   dst_pkg::row_status_type row_st;

   assign fd_idx   = fd_ff[IDX_W-1:0];
   assign tgt_idx  = tgt_ff[IDX_W-1:0];
   assign fd_ok    = (fd_ff < SLOTS_16);
   assign tgt_ok   = (tgt_ff < SLOTS_16);
   assign src_open = fd_ok && (src_state_ff == dst_pkg::SLOT_OPEN);

   assign req_ready = (fsm_ff == dst_pkg::FSM_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_load  = (fsm_ff == dst_pkg::FSM_DONE) && (!rsp_valid_ff || rsp_ready);

   dst_cell_row #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_row (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .wr_idx    (wr_idx),
      .sel_a     (fd_idx),
      .sel_b     (tgt_idx),
      .start_idx (tgt_idx),
      .pctl      (pctl),
      .status    (row_st)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         handle_mem[mem_widx] <= mem_wdata;
      end
      rd_a_ff <= handle_mem[fd_idx];
      rd_b_ff <= handle_mem[tgt_idx];
   end

   always_comb begin
      fsm_in        = fsm_ff;
      scan_in       = scan_ff;
      res_status_in = res_status_ff;
      res_fd_in     = res_fd_ff;
      res_hout_in   = res_hout_ff;
      res_hval_in   = res_hval_ff;
      res_fout_in   = res_fout_ff;
      wr            = '0;
      wr_idx        = fd_idx;
      pctl          = '0;
      mem_we        = 1'b0;
      mem_widx      = fd_idx;
      mem_wdata     = rd_a_ff;

      unique case (fsm_ff)
         dst_pkg::FSM_IDLE: begin
            if (req_valid) begin
               fsm_in = dst_pkg::FSM_READ;
            end
         end
         dst_pkg::FSM_READ: begin
            pctl.load = tgt_ok;
            scan_in   = tgt_idx;
            fsm_in    = dst_pkg::FSM_EVAL;
         end
         dst_pkg::FSM_EVAL: begin
            res_status_in = dst_pkg::STATUS_OK;
            res_fd_in     = '0;
            res_hout_in   = '0;
            res_hval_in   = 1'b0;
            res_fout_in   = '0;
            fsm_in        = dst_pkg::FSM_DONE;
            unique case (op_ff)
               dst_pkg::OP_LOOKUP: begin
                  if (!src_open) begin
                     res_status_in = dst_pkg::STATUS_BADF;
                  end else begin
                     res_fd_in   = fd_ff[14:0];
                     res_hout_in = 16'(rd_a_ff);
                     res_hval_in = 1'b1;
                  end
               end
               dst_pkg::OP_RESERVE: begin
                  priority if (tgt_ff[15]) begin
                     res_status_in = dst_pkg::STATUS_INVAL;
                  end else if (!tgt_ok) begin
                     res_status_in = dst_pkg::STATUS_NOSPC;
                  end else begin
                     fsm_in = dst_pkg::FSM_SCAN;
                  end
               end
               dst_pkg::OP_INSTALL: begin
                  if (!fd_ok || (src_state_ff != dst_pkg::SLOT_RESERVED)) begin
                     res_status_in = dst_pkg::STATUS_BADF;
                  end else begin
                     wr.en     = 1'b1;
                     wr.state  = dst_pkg::SLOT_OPEN;
                     wr.flags  = src_flags_ff;
                     mem_we    = 1'b1;
                     mem_wdata = HANDLE_BITS'(handle_ff);
                     res_fd_in = fd_ff[14:0];
                  end
               end
               dst_pkg::OP_DUP_TO: begin
                  priority if (tgt_ff[15]) begin
                     res_status_in = dst_pkg::STATUS_BADF;
                  end else if (fd_ff == tgt_ff) begin
                     res_status_in = dst_pkg::STATUS_INVAL;
                  end else if (!src_open) begin
                     res_status_in = dst_pkg::STATUS_BADF;
                  end else if (!tgt_ok) begin
                     res_status_in = dst_pkg::STATUS_NOSPC;
                  end else if (tgt_state_ff == dst_pkg::SLOT_RESERVED) begin
                     res_status_in = dst_pkg::STATUS_BADF;
                  end else begin
                     if (tgt_state_ff == dst_pkg::SLOT_OPEN) begin
                        res_hout_in = 16'(rd_b_ff);
                        res_hval_in = 1'b1;
                     end
                     wr.en     = 1'b1;
                     wr.state  = dst_pkg::SLOT_OPEN;
                     wr.flags  = flags_ff;
                     wr_idx    = tgt_idx;
                     mem_we    = 1'b1;
                     mem_widx  = tgt_idx;
                     mem_wdata = rd_a_ff;
                     res_fd_in = tgt_ff[14:0];
                  end
               end
               dst_pkg::OP_CLOSE: begin
                  if (!src_open) begin
                     res_status_in = dst_pkg::STATUS_BADF;
                  end else begin
                     wr.en       = 1'b1;
                     wr.state    = dst_pkg::SLOT_FREE;
                     wr.flags    = 8'd0;
                     res_fd_in   = fd_ff[14:0];
                     res_hout_in = 16'(rd_a_ff);
                     res_hval_in = 1'b1;
                  end
               end
               dst_pkg::OP_GET_FLAGS: begin
                  if (!src_open) begin
                     res_status_in = dst_pkg::STATUS_BADF;
                  end else begin
                     res_fd_in   = fd_ff[14:0];
                     res_fout_in = src_flags_ff;
                  end
               end
               dst_pkg::OP_SET_FLAGS: begin
                  if (!src_open) begin
                     res_status_in = dst_pkg::STATUS_BADF;
                  end else begin
                     wr.en     = 1'b1;
                     wr.state  = dst_pkg::SLOT_OPEN;
                     wr.flags  = flags_ff;
                     res_fd_in = fd_ff[14:0];
                  end
               end
               dst_pkg::OP_DUP_LOWEST: begin
                  priority if (!src_open) begin
                     res_status_in = dst_pkg::STATUS_BADF;
                  end else if (tgt_ff[15]) begin
                     res_status_in = dst_pkg::STATUS_INVAL;
                  end else if (!tgt_ok) begin
                     res_status_in = dst_pkg::STATUS_NOSPC;
                  end else begin
                     fsm_in = dst_pkg::FSM_SCAN;
                  end
               end
            endcase
         end
         dst_pkg::FSM_SCAN: begin
            pctl.shift = 1'b1;
            priority if (row_st.hit) begin
               wr.en    = 1'b1;
               wr.flags = {7'd0, flags_ff[0]};
               wr_idx   = scan_ff;
               if (op_ff == dst_pkg::OP_DUP_LOWEST) begin
                  wr.state  = dst_pkg::SLOT_OPEN;
                  mem_we    = 1'b1;
                  mem_widx  = scan_ff;
                  mem_wdata = rd_a_ff;
               end else begin
                  wr.state = dst_pkg::SLOT_RESERVED;
               end
               res_status_in = dst_pkg::STATUS_OK;
               res_fd_in     = 15'(scan_ff);
               fsm_in        = dst_pkg::FSM_DONE;
            end else if (scan_ff == LAST_IDX) begin
               res_status_in = dst_pkg::STATUS_NOSPC;
               res_fd_in     = '0;
               fsm_in        = dst_pkg::FSM_DONE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         dst_pkg::FSM_DONE: begin
            if (rsp_load) begin
               fsm_in = dst_pkg::FSM_IDLE;
            end
         end
         default: begin
            fsm_in = dst_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= dst_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff     <= req_op;
         fd_ff     <= $unsigned(req_fd);
         tgt_ff    <= $unsigned(req_target_fd);
         handle_ff <= req_handle;
         flags_ff  <= req_flags;
      end
      if (fsm_ff == dst_pkg::FSM_READ) begin
         src_state_ff <= row_st.state_a;
         src_flags_ff <= row_st.flags_a;
         tgt_state_ff <= row_st.state_b;
      end
      scan_ff       <= scan_in;
      res_status_ff <= res_status_in;
      res_fd_ff     <= res_fd_in;
      res_hout_ff   <= res_hout_in;
      res_hval_ff   <= res_hval_in;
      res_fout_ff   <= res_fout_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_fd_ff     <= res_fd_ff;
         rsp_hout_ff   <= res_hout_ff;
         rsp_hval_ff   <= res_hval_ff;
         rsp_fout_ff   <= res_fout_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_fd    = rsp_fd_ff;
   assign rsp_handle_out   = rsp_hout_ff;
   assign rsp_handle_valid = rsp_hval_ff;
   assign rsp_flags_out    = rsp_fout_ff;

endmodule

### src/dst_checker.sv
// ----------------------------------------------------------------------------
// dst_checker
// Port-level checks on the descriptor slot table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dst_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [2:0]         req_op,
   input logic signed [15:0] req_fd,
   input logic signed [15:0] req_target_fd,
   input logic [15:0]        req_handle,
   input logic [7:0]         req_flags,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic [14:0]        rsp_result_fd,
   input logic [15:0]        rsp_handle_out,
   input logic               rsp_handle_valid,
   input logic [7:0]         rsp_flags_out
);

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_result_fd) && $stable(rsp_handle_out))

   // a failed request reports nothing but its status
   `ASSERT_IMPLIES(a_err_clean, clock, reset, rsp_valid && (rsp_status != dst_pkg::STATUS_OK), (rsp_result_fd == 15'd0) && !rsp_handle_valid && (rsp_flags_out == 8'd0))

   // handle field is zero unless flagged
   `ASSERT_IMPLIES(a_handle_zero, clock, reset, rsp_valid && !rsp_handle_valid, rsp_handle_out == 16'd0)

   // one request at a time
   `ASSERT_NEXT(a_busy_after_xfer, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind descriptor_slot_table dst_checker u_dst_checker (.*);

### tb/descriptor_slot_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// descriptor_slot_table_tb
// Self-checking bench for the descriptor slot table. Requests are driven over
// the req channel in random bursts while the rsp channel stalls on its own
// pattern. A slot-table shadow computes the expected response of every
// accepted request, and each rsp transfer is compared field by field with the
// oldest pending expectation. Directed error and success cases come first, then a
// fill-to-exhaustion pass, a long rsp hold-off and a weighted random mix.
// ----------------------------------------------------------------------------
module descriptor_slot_table_tb;

   localparam int SLOTS = dst_pkg::SLOTS_DEFAULT;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] result_fd;
      logic [15:0] handle_out;
      logic        handle_valid;
      logic [7:0]  flags_out;
   } slot_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_op = dst_pkg::OP_LOOKUP;
   logic signed [15:0] req_fd = '0;
   logic signed [15:0] req_target_fd = '0;
   logic [15:0]        req_handle = '0;
   logic [7:0]         req_flags = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [14:0]        rsp_result_fd;
   logic [15:0]        rsp_handle_out;
   logic               rsp_handle_valid;
   logic [7:0]         rsp_flags_out;

   logic [1:0]      shadow_state  [SLOTS];
   logic [15:0]     shadow_handle [SLOTS];
   logic [7:0]      shadow_flags  [SLOTS];
   slot_result_type pending_results[$];
   slot_result_type want_rsp;
   int              mismatch_count = 0;
   int              burst_left = 0;
   int              hold_req_count = 0;
   int              hold_ack_count = 0;
   int              hold_left = 0;
   int              stall_pct = 0;
   int              stall_phase_left = 0;

   descriptor_slot_table u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_fd           (req_fd),
      .req_target_fd    (req_target_fd),
      .req_handle       (req_handle),
      .req_flags        (req_flags),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_fd    (rsp_result_fd),
      .rsp_handle_out   (rsp_handle_out),
      .rsp_handle_valid (rsp_handle_valid),
      .rsp_flags_out    (rsp_flags_out)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic bit slot_open(input int s);
      return s >= 0 && s < SLOTS && shadow_state[s] == dst_pkg::SLOT_OPEN;
   endfunction

   function automatic int lowest_free(input int start);
      for (int i = start; i < SLOTS; i++) begin
         if (shadow_state[i] == dst_pkg::SLOT_FREE) return i;
      end
      return -1;
   endfunction

   function automatic int count_slots(input logic [1:0] want);
      int n;
      n = 0;
      foreach (shadow_state[i]) if (shadow_state[i] == want) n++;
      return n;
   endfunction

   function automatic int pick_slot(input logic [1:0] want);
      int hits[$];
      foreach (shadow_state[i]) if (shadow_state[i] == want) hits.push_back(i);
      if (hits.size() == 0) return $urandom_range(SLOTS - 1);
      return hits[$urandom_range(hits.size() - 1)];
   endfunction

   // apply one request to the shadow table and return its response
   function automatic slot_result_type apply_slot_request(
      input logic [2:0]         op,
      input logic signed [15:0] fd_in,
      input logic signed [15:0] tgt_in,
      input logic [15:0]        handle,
      input logic [7:0]         flags
   );
      slot_result_type r;
      int fd, tgt, s;
      r = '0;
      fd = fd_in;
      tgt = tgt_in;
      case (op)
         dst_pkg::OP_LOOKUP: begin
            if (!slot_open(fd)) r.status = dst_pkg::STATUS_BADF;
            else begin
               r.result_fd = 15'(fd);
               r.handle_out = shadow_handle[fd];
               r.handle_valid = 1'b1;
            end
         end
         dst_pkg::OP_RESERVE: begin
            if (tgt < 0) r.status = dst_pkg::STATUS_INVAL;
            else begin
               s = lowest_free(tgt);
               if (s < 0) r.status = dst_pkg::STATUS_NOSPC;
               else begin
                  shadow_state[s] = dst_pkg::SLOT_RESERVED;
                  shadow_flags[s] = {7'd0, flags[0]};
                  r.result_fd = 15'(s);
               end
            end
         end
         dst_pkg::OP_INSTALL: begin
            if (fd < 0 || fd >= SLOTS || shadow_state[fd] != dst_pkg::SLOT_RESERVED)
               r.status = dst_pkg::STATUS_BADF;
            else begin
               shadow_handle[fd] = handle;
               shadow_state[fd] = dst_pkg::SLOT_OPEN;
               r.result_fd = 15'(fd);
            end
         end
         dst_pkg::OP_DUP_TO: begin
            if (tgt < 0) r.status = dst_pkg::STATUS_BADF;
            else if (fd == tgt) r.status = dst_pkg::STATUS_INVAL;
            else if (!slot_open(fd)) r.status = dst_pkg::STATUS_BADF;
            else if (tgt >= SLOTS) r.status = dst_pkg::STATUS_NOSPC;
            else if (shadow_state[tgt] == dst_pkg::SLOT_RESERVED)
               r.status = dst_pkg::STATUS_BADF;
            else begin
               if (shadow_state[tgt] == dst_pkg::SLOT_OPEN) begin
                  r.handle_out = shadow_handle[tgt];
                  r.handle_valid = 1'b1;
               end
               shadow_handle[tgt] = shadow_handle[fd];
               shadow_flags[tgt] = flags;
               shadow_state[tgt] = dst_pkg::SLOT_OPEN;
               r.result_fd = 15'(tgt);
            end
         end
         dst_pkg::OP_CLOSE: begin
            if (!slot_open(fd)) r.status = dst_pkg::STATUS_BADF;
            else begin
               r.handle_out = shadow_handle[fd];
               r.handle_valid = 1'b1;
               shadow_state[fd] = dst_pkg::SLOT_FREE;
               shadow_flags[fd] = 8'd0;
               r.result_fd = 15'(fd);
            end
         end
         dst_pkg::OP_GET_FLAGS: begin
            if (!slot_open(fd)) r.status = dst_pkg::STATUS_BADF;
            else begin
               r.flags_out = shadow_flags[fd];
               r.result_fd = 15'(fd);
            end
         end
         dst_pkg::OP_SET_FLAGS: begin
            if (!slot_open(fd)) r.status = dst_pkg::STATUS_BADF;
            else begin
               shadow_flags[fd] = flags;
               r.result_fd = 15'(fd);
            end
         end
         default: begin
            if (!slot_open(fd)) r.status = dst_pkg::STATUS_BADF;
            else if (tgt < 0) r.status = dst_pkg::STATUS_INVAL;
            else begin
               s = lowest_free(tgt);
               if (s < 0) r.status = dst_pkg::STATUS_NOSPC;
               else begin
                  shadow_handle[s] = shadow_handle[fd];
                  shadow_flags[s] = {7'd0, flags[0]};
                  shadow_state[s] = dst_pkg::SLOT_OPEN;
                  r.result_fd = 15'(s);
               end
            end
         end
      endcase
      return r;
   endfunction

   // offer one request; idle between bursts, hold until transfer
   task automatic send_request(
      input logic [2:0]  op,
      input int          fd,
      input int          tgt,
      input logic [15:0] handle,
      input logic [7:0]  flags
   );
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(7) == 0) ? 150 : $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_fd <= fd[15:0];
      req_target_fd <= tgt[15:0];
      req_handle <= handle;
      req_flags <= flags;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_slot_request(op, fd[15:0], tgt[15:0], handle, flags));
      burst_left--;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic random_request();
      logic [2:0] op;
      int fd, tgt, pick;
      pick = $urandom_range(99);
      if (count_slots(dst_pkg::SLOT_FREE) < 4 && $urandom_range(1) == 0)
         op = dst_pkg::OP_CLOSE;
      else if (pick < 18) op = dst_pkg::OP_RESERVE;
      else if (pick < 36) op = dst_pkg::OP_INSTALL;
      else if (pick < 46) op = dst_pkg::OP_LOOKUP;
      else if (pick < 56) op = dst_pkg::OP_CLOSE;
      else if (pick < 64) op = dst_pkg::OP_GET_FLAGS;
      else if (pick < 72) op = dst_pkg::OP_SET_FLAGS;
      else if (pick < 84) op = dst_pkg::OP_DUP_TO;
      else if (pick < 96) op = dst_pkg::OP_DUP_LOWEST;
      else op = 3'($urandom_range(7));

      fd = (op == dst_pkg::OP_INSTALL) ? pick_slot(dst_pkg::SLOT_RESERVED)
                                       : pick_slot(dst_pkg::SLOT_OPEN);
      pick = $urandom_range(99);
      if (pick < 10) fd = $signed(16'($urandom));
      else if (pick < 15) fd = $urandom_range(SLOTS + 3);

      pick = $urandom_range(99);
      if (op == dst_pkg::OP_DUP_TO) begin
         if (pick < 50) tgt = pick_slot(dst_pkg::SLOT_OPEN);
         else if (pick < 80) tgt = pick_slot(dst_pkg::SLOT_FREE);
         else if (pick < 90) tgt = pick_slot(dst_pkg::SLOT_RESERVED);
         else tgt = $signed(16'($urandom));
      end else begin
         if (pick < 70) tgt = $urandom_range(7);
         else if (pick < 90) tgt = $urandom_range(SLOTS + 2);
         else tgt = $signed(16'($urandom));
      end
      send_request(op, fd, tgt, 16'($urandom), 8'($urandom));
   endtask

   task automatic test_directed_ops();
      send_request(dst_pkg::OP_LOOKUP, 0, 0, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_CLOSE, -32768, 0, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_GET_FLAGS, 32767, 0, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_RESERVE, 0, -1, 16'h0000, 8'hFF);
      send_request(dst_pkg::OP_RESERVE, 0, 0, 16'h0000, 8'hFF);
      send_request(dst_pkg::OP_INSTALL, 0, 0, 16'hFFFF, 8'h00);
      send_request(dst_pkg::OP_INSTALL, 0, 0, 16'h1234, 8'h00);
      send_request(dst_pkg::OP_LOOKUP, 0, 0, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_GET_FLAGS, 0, 0, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_SET_FLAGS, 0, 0, 16'h0000, 8'hA5);
      send_request(dst_pkg::OP_GET_FLAGS, 0, 0, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_RESERVE, 0, SLOTS - 1, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_DUP_TO, 0, SLOTS - 1, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_INSTALL, SLOTS - 1, 0, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_DUP_TO, 0, SLOTS - 1, 16'h0000, 8'h5A);
      send_request(dst_pkg::OP_DUP_TO, 0, 0, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_DUP_TO, 0, -32768, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_DUP_TO, 5, 7, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_DUP_TO, 0, SLOTS, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_DUP_TO, 0, 32767, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_DUP_LOWEST, 0, -5, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_DUP_LOWEST, 3, -5, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_DUP_LOWEST, 0, SLOTS - 1, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_DUP_LOWEST, 0, 10, 16'h0000, 8'hFE);
      send_request(dst_pkg::OP_CLOSE, 10, 0, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_RESERVE, 0, SLOTS, 16'h0000, 8'h01);
      send_request(dst_pkg::OP_INSTALL, SLOTS, 0, 16'h0000, 8'h00);
      send_request(dst_pkg::OP_SET_FLAGS, -1, 0, 16'h0000, 8'hFF);
   endtask

   task automatic test_fill_table();
      while (count_slots(dst_pkg::SLOT_FREE) > 0) begin
         if ($urandom_range(1) == 0)
            send_request(dst_pkg::OP_RESERVE, 0, $urandom_range(3), 16'($urandom),
                         8'($urandom));
         else
            send_request(dst_pkg::OP_DUP_LOWEST, pick_slot(dst_pkg::SLOT_OPEN),
                         $urandom_range(3), 16'($urandom), 8'($urandom));
      end
      while (count_slots(dst_pkg::SLOT_RESERVED) > 0)
         send_request(dst_pkg::OP_INSTALL, pick_slot(dst_pkg::SLOT_RESERVED), 0,
                      16'($urandom), 8'($urandom));
      repeat (4) send_request(dst_pkg::OP_RESERVE, 0, $urandom_range(SLOTS - 1),
                              16'h0000, 8'h01);
      repeat (4) send_request(dst_pkg::OP_DUP_LOWEST, pick_slot(dst_pkg::SLOT_OPEN),
                              $urandom_range(SLOTS - 1), 16'h0000, 8'h01);
      repeat (4) send_request(dst_pkg::OP_DUP_TO, pick_slot(dst_pkg::SLOT_OPEN),
                              pick_slot(dst_pkg::SLOT_OPEN), 16'h0000, 8'($urandom));
      repeat (40) send_request(dst_pkg::OP_CLOSE, pick_slot(dst_pkg::SLOT_OPEN), 0,
                               16'h0000, 8'h00);
   endtask

   task automatic test_backpressure();
      hold_req_count++;
      repeat (16) random_request();
      wait_drain();
   endtask

   task automatic test_random_mix();
      for (int n = 1; n <= 900; n++) begin
         random_request();
         if (n % 300 == 0) hold_req_count++;
         if (n % 120 == 0) wait_drain();
      end
   endtask

   // rsp stall pattern: phases of differing stall rate, plus a long hold-off
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         case ($urandom_range(2))
            0: stall_pct = 0;
            1: stall_pct = 30;
            default: stall_pct = 75;
         endcase
         stall_phase_left = $urandom_range(20, 400);
      end
      stall_phase_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_req_count != hold_ack_count) begin
         hold_ack_count = hold_req_count;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected rsp transfer: status %0d result_fd %0d",
                   rsp_status, rsp_result_fd);
            mismatch_count++;
         end else begin
            want_rsp = pending_results.pop_front();
            if (rsp_status !== want_rsp.status) begin
               $error("status mismatch: expected %0d, actual %0d",
                      want_rsp.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_result_fd !== want_rsp.result_fd) begin
               $error("result_fd mismatch: expected %0d, actual %0d",
                      want_rsp.result_fd, rsp_result_fd);
               mismatch_count++;
            end
            if (rsp_handle_out !== want_rsp.handle_out) begin
               $error("handle_out mismatch: expected 0x%04h, actual 0x%04h",
                      want_rsp.handle_out, rsp_handle_out);
               mismatch_count++;
            end
            if (rsp_handle_valid !== want_rsp.handle_valid) begin
               $error("handle_valid mismatch: expected %0d, actual %0d",
                      want_rsp.handle_valid, rsp_handle_valid);
               mismatch_count++;
            end
            if (rsp_flags_out !== want_rsp.flags_out) begin
               $error("flags_out mismatch: expected 0x%02h, actual 0x%02h",
                      want_rsp.flags_out, rsp_flags_out);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      foreach (shadow_state[i]) begin
         shadow_state[i] = dst_pkg::SLOT_FREE;
         shadow_handle[i] = 16'd0;
         shadow_flags[i] = 8'd0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      wait_drain();
      test_fill_table();
      wait_drain();
      test_backpressure();
      test_random_mix();
      wait_drain();
      repeat (80) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
